### rtl/core/srm_pkg.sv
// Shared types, constants and helper functions of the string rule matcher.
`timescale 1ns / 1ps
`default_nettype none

package srm_pkg;

  localparam int MAX_PATTERN_DEF = 32;
  localparam int COUNT_BITS_DEF  = 16;
  localparam int CFG_DATA_BITS   = 64;
  localparam int CFG_INDEX_BITS  = 3;
  localparam int PATTERN_WORDS   = 4;
  localparam int PATTERN_BITS    = PATTERN_WORDS * CFG_DATA_BITS;
  localparam int LENGTH_BITS     = 6;
  localparam int RULE_BITS       = 4;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QUEUE_PTR_BITS  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [RULE_BITS-1:0] {
    RULE_EQ,
    RULE_NE,
    RULE_BEGINS,
    RULE_NOTBEGIN,
    RULE_ENDS,
    RULE_NOTEND,
    RULE_CONTAINS,
    RULE_NOTCONTAIN,
    RULE_ANY,
    RULE_NOTANY,
    RULE_ALL,
    RULE_NOTALL
  } rule_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_RULE,
    REG_CASE_SENSITIVE,
    REG_PATTERN_LENGTH,
    REG_PATTERN_WORD_0,
    REG_PATTERN_WORD_1,
    REG_PATTERN_WORD_2,
    REG_PATTERN_WORD_3
  } reg_index_t;

  typedef struct packed {
    rule_t                    rule;
    logic                     case_sensitive;
    logic [LENGTH_BITS-1:0]   pattern_length;
    logic [PATTERN_BITS-1:0]  pattern;
  } cfg_t;

  // One queued request: a character (possibly absent) and the end-of-object mark.
  typedef struct packed {
    logic       has_char;
    logic       last;
    logic [7:0] ch;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // Lowers ASCII A-Z unless the comparison is case sensitive.
  function automatic logic [7:0] fold(input logic [7:0] c, input logic case_sensitive);
    logic [7:0] r;
    r = c;
    if (!case_sensitive && c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/srm_front.sv
// Front end: accepts requests, folds the character and drops empty non-final requests.
`timescale 1ns / 1ps
`default_nettype none

module srm_front
  import srm_pkg::*;
(
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] object_char,
  input  wire logic       char_valid,
  input  wire logic       is_last,
  input  wire logic       case_sensitive,
  input  wire qstat_t     q_stat,
  output logic            q_push,
  output item_t           q_item
);

  // Requests with no character and no end mark change nothing and are not queued.
  assign in_stall = q_stat.full;
  assign q_push   = in_valid && !q_stat.full && (char_valid || is_last);

  always_comb begin
    q_item.has_char = char_valid;
    q_item.last     = is_last;
    q_item.ch       = fold(object_char, case_sensitive);
  end

endmodule

`default_nettype wire

### rtl/core/srm_queue.sv
// Short request queue between the front end and the match engine.
`timescale 1ns / 1ps
`default_nettype none

module srm_queue
  import srm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t push_item,
  input  wire logic  pop,
  output item_t      head,
  output qstat_t     stat
);

  item_t                     entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [QUEUE_CNT_BITS-1:0] fill;

  function automatic logic [QUEUE_PTR_BITS-1:0] ptr_inc(input logic [QUEUE_PTR_BITS-1:0] p);
    logic [QUEUE_PTR_BITS-1:0] r;
    r = (p == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  assign head       = entries[rd_ptr];
  assign stat.full  = (fill == QUEUE_CNT_BITS'(QUEUE_DEPTH));
  assign stat.empty = (fill == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

### rtl/core/srm_back.sv
// Match engine: per-character state update, rule evaluation and the result register.
`timescale 1ns / 1ps
`default_nettype none

module srm_back
  import srm_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire item_t head,
  input  wire logic  q_empty,
  output logic       pop,
  output logic       out_valid,
  input  wire logic  out_stall,
  output logic       matched
);

  localparam int LEN_BITS = $clog2(MAX_PATTERN + 1);

  logic [COUNT_BITS-1:0]  count;
  logic                   prefix_ok;
  logic                   substring_seen;
  logic [MAX_PATTERN-1:0] seen;
  logic [MAX_PATTERN-1:0] match;

  logic [COUNT_BITS-1:0]  cur_count;
  logic                   cur_prefix;
  logic                   cur_sub;
  logic [MAX_PATTERN-1:0] cur_seen;
  logic [MAX_PATTERN-1:0] cur_match;
  logic [MAX_PATTERN:0]   prev_match;
  logic [MAX_PATTERN-1:0] hit;
  logic [MAX_PATTERN-1:0] len_mask;
  logic [LEN_BITS-1:0]    len;
  logic [COUNT_BITS-1:0]  len_ext;
  logic                   pref_fail;
  logic                   win;
  logic                   eq_ok;
  logic                   begins_ok;
  logic                   ends_ok;
  logic                   contains_ok;
  logic                   any_ok;
  logic                   all_ok;
  logic                   result;

  assign len = (cfg.pattern_length > LENGTH_BITS'(MAX_PATTERN)) ?
               LEN_BITS'(MAX_PATTERN) : cfg.pattern_length[LEN_BITS-1:0];
  assign len_ext = COUNT_BITS'(len);

  // A final request needs room in the result register; others always go through.
  assign pop = !q_empty && (!head.last || !out_valid || !out_stall);

  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      hit[i]      = (head.ch == fold(cfg.pattern[8*i +: 8], cfg.case_sensitive));
      len_mask[i] = (LEN_BITS'(i) < len);
    end

    pref_fail = 1'b0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (count == COUNT_BITS'(i) && len_mask[i] && !hit[i]) begin
        pref_fail = 1'b1;
      end
    end

    // match[i] means pattern characters 0..i end at the newest character.
    prev_match = {match, 1'b1};
    cur_count  = count;
    cur_prefix = prefix_ok;
    cur_match  = match;
    cur_seen   = seen;
    cur_sub    = substring_seen;
    if (head.has_char) begin
      if (pref_fail) begin
        cur_prefix = 1'b0;
      end
      if (count != '1) begin
        cur_count = count + 1'b1;
      end
      cur_match = prev_match[MAX_PATTERN-1:0] & hit;
      cur_seen  = seen | (hit & len_mask);
    end

    win = 1'b0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (len == LEN_BITS'(i + 1) && cur_match[i]) begin
        win = 1'b1;
      end
    end
    if (head.has_char && win) begin
      cur_sub = 1'b1;
    end

    eq_ok       = (cur_count == len_ext) && cur_prefix;
    begins_ok   = (cur_count >= len_ext) && cur_prefix;
    ends_ok     = (cur_count > len_ext) && ((len == '0) || win);
    contains_ok = (len == '0) || cur_sub;
    any_ok      = |(cur_seen & len_mask);
    all_ok      = &(cur_seen | ~len_mask);

    unique case (cfg.rule)
      RULE_EQ:         result = eq_ok;
      RULE_NE:         result = !eq_ok;
      RULE_BEGINS:     result = begins_ok;
      RULE_NOTBEGIN:   result = !begins_ok;
      RULE_ENDS:       result = ends_ok;
      RULE_NOTEND:     result = !ends_ok;
      RULE_CONTAINS:   result = contains_ok;
      RULE_NOTCONTAIN: result = !contains_ok;
      RULE_ANY:        result = any_ok;
      RULE_NOTANY:     result = !any_ok;
      RULE_ALL:        result = all_ok;
      RULE_NOTALL:     result = !all_ok;
      default:         result = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count          <= '0;
      prefix_ok      <= 1'b1;
      substring_seen <= 1'b0;
      seen           <= '0;
      match          <= '0;
    end else if (pop) begin
      if (head.last) begin
        count          <= '0;
        prefix_ok      <= 1'b1;
        substring_seen <= 1'b0;
        seen           <= '0;
        match          <= '0;
      end else begin
        count          <= cur_count;
        prefix_ok      <= cur_prefix;
        substring_seen <= cur_sub;
        seen           <= cur_seen;
        match          <= cur_match;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && head.last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      matched <= result;
    end
  end

endmodule

`default_nettype wire

### rtl/core/string_rule_matcher.sv
// Top level of the string rule matcher: configuration registers and block wiring.
//
// The object string streams in on the input channel one character per request
// (object_char with char_valid), and the request that carries is_last closes the
// object. Exactly one result request (matched) follows each closing request; all
// other requests produce nothing. A request with char_valid low and is_last low
// is taken and ignored. The rule, case mode, pattern length and pattern words are
// written through the cfg_write / cfg_index / cfg_data port. The user must write
// them only while the block is idle; the block itself does not enforce this.
//
// Throughput is one input request per cycle while in_stall is low; the match engine
// compares the new character against all pattern positions in parallel. An accepted
// closing request is written into the request queue and, once the result register
// has room, passes through the match engine into that register, driving out_valid.
//
// A synchronous reset clears the configuration to zero, empties the queue, drops
// any pending result and returns the object state to its start values.
// When the receiver stalls, the result register holds its value, the engine stops
// at the next closing request, the two-entry queue fills and in_stall rises.
`timescale 1ns / 1ps
`default_nettype none

module string_rule_matcher
  import srm_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_write,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [7:0]                object_char,
  input  wire logic                      char_valid,
  input  wire logic                      is_last,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic                           matched
);

  cfg_t   cfg;
  qstat_t q_stat;
  item_t  q_item;
  item_t  head;
  logic   q_push;
  logic   pop;

  // Configuration registers. Writes to unused indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_RULE:           cfg.rule           <= rule_t'(cfg_data[RULE_BITS-1:0]);
        REG_CASE_SENSITIVE: cfg.case_sensitive <= cfg_data[0];
        REG_PATTERN_LENGTH: cfg.pattern_length <= cfg_data[LENGTH_BITS-1:0];
        REG_PATTERN_WORD_0: cfg.pattern[0*CFG_DATA_BITS +: CFG_DATA_BITS] <= cfg_data;
        REG_PATTERN_WORD_1: cfg.pattern[1*CFG_DATA_BITS +: CFG_DATA_BITS] <= cfg_data;
        REG_PATTERN_WORD_2: cfg.pattern[2*CFG_DATA_BITS +: CFG_DATA_BITS] <= cfg_data;
        REG_PATTERN_WORD_3: cfg.pattern[3*CFG_DATA_BITS +: CFG_DATA_BITS] <= cfg_data;
        default: ;
      endcase
    end
  end

  srm_front u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .object_char    (object_char),
    .char_valid     (char_valid),
    .is_last        (is_last),
    .case_sensitive (cfg.case_sensitive),
    .q_stat         (q_stat),
    .q_push         (q_push),
    .q_item         (q_item)
  );

  srm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_item),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  srm_back #(
    .MAX_PATTERN (MAX_PATTERN),
    .COUNT_BITS  (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head),
    .q_empty   (q_stat.empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .matched   (matched)
  );

  // A new result appears only after the engine took a closing request.
  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(pop && head.last))
    else $error("result appeared without a closing request");

  // A queued request is visible to the engine on the next cycle.
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    q_push |=> !q_stat.empty)
    else $error("queued request lost");

  // The engine never takes a closing request while a stalled result is pending.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !(pop && head.last))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

### tb/tb_string_rule_matcher.sv
// Self-checking testbench of the string rule matcher: directed and random objects.
`timescale 1ns / 1ps

// The testbench streams object strings into the matcher one character per request
// and checks every match bit against a predictor that runs in step with the
// accepted requests. A short table of hand-picked objects comes first; random
// settings and objects follow.
module tb_string_rule_matcher;
  import srm_pkg::*;

  localparam int MAX_PAT = MAX_PATTERN_DEF;
  localparam logic [COUNT_BITS_DEF-1:0] COUNT_MAX = '1;

  // Rule codes above the last named rule answer no match.
  localparam logic [RULE_BITS-1:0] RULE_RESERVED = 4'd15;
  localparam int NAMED_RULES = 12;

  // How an object is closed: on its last character, by an empty end marker, or
  // on its last character with an ignored empty request slipped in earlier.
  localparam int CLOSE_ON_CHAR = 0;
  localparam int CLOSE_ON_MARKER = 1;
  localparam int CLOSE_WITH_NOISE = 2;

  localparam int RANDOM_ITEMS = 920;
  localparam int SETTLE_CYCLES = 6;
  localparam int IDLE_PERCENT = 19;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [7:0] ch;
    logic       cv;
    logic       last;
  } char_req_t;

  typedef struct packed {
    logic [RULE_BITS-1:0]    rule;
    logic                    cs;
    logic [LENGTH_BITS-1:0]  plen;
    logic [PATTERN_BITS-1:0] pattern;
  } match_setup_t;

  typedef struct {
    bit           write_setup;
    match_setup_t setup;
    string        text;
    int           close_mode;
    int           known_match;
  } directed_row_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [7:0]                object_char = '0;
  logic                      char_valid = 1'b0;
  logic                      is_last = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      matched;

  // Settings as the matcher holds them, and the per-object state of the predictor.
  match_setup_t mirror = '0;
  logic [7:0]   window_chars [MAX_PAT];
  logic [COUNT_BITS_DEF-1:0] obj_count;
  bit           prefix_ok;
  bit           substring_seen;
  bit           pat_seen [MAX_PAT];

  bit            pending_matches [$];
  char_req_t     object_reqs [$];
  directed_row_t directed_rows [$];
  int            items_sent = 0;
  int            error_count = 0;
  bit            calm = 1'b0;

  string_rule_matcher i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .object_char(object_char),
    .char_valid (char_valid),
    .is_last    (is_last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .matched    (matched)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // In case-insensitive mode only the ASCII capitals are lowered; the neighbors
  // of A and Z stay as they are.
  function automatic logic [7:0] lower_char(input logic [7:0] c);
    if (!mirror.cs && c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'h20;
    end
    return c;
  endfunction

  function automatic logic [7:0] raw_pattern_char(input int i);
    return mirror.pattern[8*i +: 8];
  endfunction

  function automatic logic [7:0] pattern_char(input int i);
    return lower_char(raw_pattern_char(i));
  endfunction

  // A length register above the pattern store saturates to the full store.
  function automatic int pattern_len();
    return (mirror.plen > MAX_PAT) ? MAX_PAT : int'(mirror.plen);
  endfunction

  // True when the newest len characters, oldest first, spell the pattern.
  function automatic bit tail_matches(input int len);
    for (int k = 0; k < len; k++) begin
      if (lower_char(window_chars[len-1-k]) != pattern_char(k)) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic void clear_object();
    for (int i = 0; i < MAX_PAT; i++) begin
      window_chars[i] = '0;
      pat_seen[i] = 1'b0;
    end
    obj_count = '0;
    prefix_ok = 1'b1;
    substring_seen = 1'b0;
  endfunction

  // Advances the predictor by one accepted request. Returns 1 when the request
  // closes the object, with the match bit in m.
  function automatic bit predict_step(input char_req_t r, output bit m);
    int len;
    logic [7:0] fc;
    bit any_hit;
    bit all_hit;
    bit eq_ok;
    bit begins_ok;
    bit ends_ok;
    bit contains_ok;
    len = pattern_len();
    m = 1'b0;
    if (r.cv) begin
      fc = lower_char(r.ch);
      for (int i = MAX_PAT - 1; i > 0; i--) begin
        window_chars[i] = window_chars[i-1];
      end
      window_chars[0] = r.ch;
      if (obj_count < len && fc != pattern_char(int'(obj_count))) begin
        prefix_ok = 1'b0;
      end
      if (obj_count != COUNT_MAX) begin
        obj_count++;
      end
      for (int i = 0; i < len; i++) begin
        if (fc == pattern_char(i)) begin
          pat_seen[i] = 1'b1;
        end
      end
      if (len > 0 && obj_count >= len && tail_matches(len)) begin
        substring_seen = 1'b1;
      end
    end
    if (!r.last) begin
      return 1'b0;
    end
    any_hit = 1'b0;
    all_hit = 1'b1;
    for (int i = 0; i < len; i++) begin
      if (pat_seen[i]) begin
        any_hit = 1'b1;
      end else begin
        all_hit = 1'b0;
      end
    end
    eq_ok = (obj_count == len) && prefix_ok;
    begins_ok = (obj_count >= len) && prefix_ok;
    ends_ok = (obj_count > len) && tail_matches(len);
    contains_ok = (len == 0) || substring_seen;
    case (mirror.rule)
      RULE_EQ:         m = eq_ok;
      RULE_NE:         m = !eq_ok;
      RULE_BEGINS:     m = begins_ok;
      RULE_NOTBEGIN:   m = !begins_ok;
      RULE_ENDS:       m = ends_ok;
      RULE_NOTEND:     m = !ends_ok;
      RULE_CONTAINS:   m = contains_ok;
      RULE_NOTCONTAIN: m = !contains_ok;
      RULE_ANY:        m = any_hit;
      RULE_NOTANY:     m = !any_hit;
      RULE_ALL:        m = all_hit;
      RULE_NOTALL:     m = !all_hit;
      default:         m = 1'b0;
    endcase
    clear_object();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Characters around the case-folding boundaries, so that random patterns and
  // objects hit each other often.
  function automatic logic [7:0] alpha_char();
    case ($urandom_range(7))
      0: return 8'h61;
      1: return 8'h62;
      2: return 8'h41;
      3: return 8'h42;
      4: return 8'h40;
      5: return 8'h5B;
      6: return 8'h60;
      default: return 8'h7B;
    endcase
  endfunction

  // Flips the case of a letter half of the time.
  function automatic logic [7:0] maybe_flip(input logic [7:0] c);
    logic [7:0] lc;
    lc = c | 8'h20;
    if (lc >= 8'h61 && lc <= 8'h7A && $urandom_range(1)) begin
      return c ^ 8'h20;
    end
    return c;
  endfunction

  // A character that is often one of the pattern, otherwise a near miss.
  function automatic logic [7:0] near_char();
    int len;
    len = pattern_len();
    if (len > 0 && $urandom_range(1)) begin
      return maybe_flip(raw_pattern_char($urandom_range(len - 1)));
    end
    return ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : alpha_char();
  endfunction

  // Turns a byte string into requests, closed as close_mode says. An empty
  // object can only be closed by an end marker.
  function automatic void frame_object(input logic [7:0] bytes [$], input int close_mode);
    int n;
    int noise_at;
    char_req_t r;
    n = bytes.size();
    object_reqs.delete();
    noise_at = (close_mode == CLOSE_WITH_NOISE && n > 0) ? $urandom_range(n - 1) : -1;
    for (int i = 0; i < n; i++) begin
      if (i == noise_at) begin
        r = '{ch: 8'($urandom_range(255)), cv: 1'b0, last: 1'b0};
        object_reqs.push_back(r);
      end
      r = '{ch: bytes[i], cv: 1'b1,
            last: (i == n - 1) && (close_mode != CLOSE_ON_MARKER)};
      object_reqs.push_back(r);
    end
    if (n == 0 || close_mode == CLOSE_ON_MARKER) begin
      r = '{ch: 8'($urandom_range(255)), cv: 1'b0, last: 1'b1};
      object_reqs.push_back(r);
    end
  endfunction

  function automatic void text_object(input string s, input int close_mode);
    logic [7:0] bytes [$];
    for (int i = 0; i < s.len(); i++) begin
      bytes.push_back(s[i]);
    end
    frame_object(bytes, close_mode);
  endfunction

  // Random objects are mostly built around the pattern: whole, with something
  // before or after, cut short or with one bit changed. The rest is loose text
  // from the pattern alphabet or plain random bytes.
  function automatic void compose_object();
    logic [7:0] bytes [$];
    int len;
    int kind;
    int body;
    int pick;
    int close_mode;
    len = pattern_len();
    kind = $urandom_range(7);
    if (kind == 2 || kind == 3) begin
      repeat ($urandom_range(1, 3)) bytes.push_back(near_char());
    end
    case (kind)
      0, 1, 2, 3, 4, 7: begin
        body = (kind == 4) ? $urandom_range(len) : len;
        for (int i = 0; i < body; i++) begin
          bytes.push_back(maybe_flip(raw_pattern_char(i)));
        end
        if (kind == 7 && bytes.size() > 0) begin
          pick = $urandom_range(bytes.size() - 1);
          bytes[pick] = bytes[pick] ^ (8'h01 << $urandom_range(7));
        end
      end
      5: repeat ($urandom_range(6)) bytes.push_back(near_char());
      default: repeat ($urandom_range(8)) bytes.push_back(8'($urandom_range(255)));
    endcase
    if (kind == 1 || kind == 3) begin
      repeat ($urandom_range(1, 3)) bytes.push_back(near_char());
    end
    pick = $urandom_range(99);
    close_mode = (pick < 70) ? CLOSE_ON_CHAR : (pick < 85) ? CLOSE_ON_MARKER : CLOSE_WITH_NOISE;
    frame_object(bytes, close_mode);
  endfunction

  // Mostly short patterns; now and then the full store or an oversized length.
  function automatic match_setup_t random_setup();
    match_setup_t s;
    int pick;
    s.rule = ($urandom_range(99) < 8) ? 4'($urandom_range(NAMED_RULES, 15))
                                      : 4'($urandom_range(NAMED_RULES - 1));
    s.cs = 1'($urandom_range(1));
    pick = $urandom_range(99);
    if (pick < 70) begin
      s.plen = 6'($urandom_range(6));
    end else if (pick < 85) begin
      s.plen = 6'($urandom_range(7, 16));
    end else if (pick < 93) begin
      s.plen = 6'(MAX_PAT);
    end else begin
      s.plen = 6'($urandom_range(MAX_PAT + 1, 63));
    end
    for (int i = 0; i < MAX_PAT; i++) begin
      s.pattern[8*i +: 8] = ($urandom_range(9) < 7) ? alpha_char() : 8'($urandom_range(255));
    end
    return s;
  endfunction

  function automatic void add_row(input bit write_setup, input logic [RULE_BITS-1:0] rule,
                                  input bit cs, input logic [LENGTH_BITS-1:0] plen,
                                  input logic [PATTERN_BITS-1:0] pattern, input string text,
                                  input int close_mode, input int known_match);
    directed_row_t row;
    row.write_setup = write_setup;
    row.setup = '{rule: rule, cs: cs, plen: plen, pattern: pattern};
    row.text = text;
    row.close_mode = close_mode;
    row.known_match = known_match;
    directed_rows.push_back(row);
  endfunction

  function automatic logic [PATTERN_BITS-1:0] pack_text(input string s);
    logic [PATTERN_BITS-1:0] p;
    p = '0;
    for (int i = 0; i < s.len() && i < MAX_PAT; i++) begin
      p[8*i +: 8] = s[i];
    end
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Bus tasks
  // ---------------------------------------------------------------------------

  // Writes all seven registers back to back. The write enable stays high across
  // the burst; the unused upper data bits carry noise, which the matcher must
  // ignore.
  task automatic load_setup(input match_setup_t s);
    logic [CFG_DATA_BITS-1:0] word;
    for (int r = REG_RULE; r <= REG_PATTERN_WORD_3; r++) begin
      word = {$urandom(), $urandom()};
      case (reg_index_t'(r))
        REG_RULE:           word[RULE_BITS-1:0] = s.rule;
        REG_CASE_SENSITIVE: word[0] = s.cs;
        REG_PATTERN_LENGTH: word[LENGTH_BITS-1:0] = s.plen;
        default: begin
          word = s.pattern[CFG_DATA_BITS*(r - REG_PATTERN_WORD_0) +: CFG_DATA_BITS];
        end
      endcase
      cfg_write <= 1'b1;
      cfg_index <= reg_index_t'(r);
      cfg_data <= word;
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    mirror = s;
  endtask

  // Presents one request, with random idle cycles before it unless the run is in
  // its calm stretch, and waits until the matcher takes it. Each further idle
  // cycle is drawn with the idle percentage, so that about that share of cycles
  // stays idle. The valid line is left high so that back-to-back requests need
  // only one assignment per edge.
  // A known match from the directed table overrides the predictor's answer.
  task automatic send_char(input char_req_t r, input int known_match);
    int gap;
    bit m;
    gap = 0;
    while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
      gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    object_char <= r.ch;
    char_valid <= r.cv;
    is_last <= r.last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (predict_step(r, m)) begin
      pending_matches.push_back((known_match >= 0) ? (known_match != 0) : m);
    end
    if (r.cv || r.last) begin
      items_sent++;
    end
  endtask

  task automatic send_object(input int known_match);
    foreach (object_reqs[i]) begin
      send_char(object_reqs[i], known_match);
    end
  endtask

  // Drops valid, waits for every expected result, then lets the pipeline run
  // dry. Registers are only rewritten after this.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void note_failure(input string what, input bit want, input bit got);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("%0t: %s: expected matched=%0b, got %0b", $realtime, what, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stalls, and the check of every accepted result
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
  end

  always @(posedge clk) begin
    bit want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_matches.size() == 0) begin
        note_failure("result with no request waiting", 1'b0, matched);
      end else begin
        want = pending_matches.pop_front();
        if (matched !== want) begin
          note_failure("match bit differs", want, matched);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int base;

    clear_object();

    // Directed objects. The first one runs on the settings straight out of
    // reset: rule equals with an empty pattern, so only an empty object matches.
    add_row(1'b0, RULE_EQ, 1'b0, 6'd0, '0, "", CLOSE_ON_MARKER, 1);
    // Case folding covers A to Z only, not the characters around them.
    add_row(1'b1, RULE_EQ, 1'b0, 6'd2, pack_text("AZ"), "az", CLOSE_ON_CHAR, 1);
    add_row(1'b1, RULE_NE, 1'b0, 6'd2, pack_text("@["), "`{", CLOSE_ON_CHAR, 1);
    add_row(1'b1, RULE_EQ, 1'b1, 6'd2, pack_text("AZ"), "az", CLOSE_ON_CHAR, 0);
    add_row(1'b1, RULE_BEGINS, 1'b1, 6'd2, pack_text("ab"), "abz", CLOSE_ON_CHAR, 1);
    // An object shorter than the pattern cannot begin with it.
    add_row(1'b1, RULE_NOTBEGIN, 1'b0, 6'd2, pack_text("ab"), "a", CLOSE_ON_CHAR, 1);
    // Ends is strict: an object equal to the pattern does not end with it.
    add_row(1'b1, RULE_ENDS, 1'b0, 6'd2, pack_text("ab"), "ab", CLOSE_ON_CHAR, 0);
    add_row(1'b1, RULE_NOTEND, 1'b0, 6'd1, pack_text("b"), "ab", CLOSE_ON_CHAR, 0);
    // With an empty pattern: contains and all hold, any does not, ends holds for
    // any object that has a character.
    add_row(1'b1, RULE_CONTAINS, 1'b0, 6'd0, '0, "", CLOSE_ON_MARKER, 1);
    add_row(1'b1, RULE_NOTCONTAIN, 1'b0, 6'd1, pack_text("b"), "ab", CLOSE_ON_CHAR, 0);
    add_row(1'b1, RULE_ANY, 1'b0, 6'd0, '0, "x", CLOSE_ON_CHAR, 0);
    add_row(1'b1, RULE_NOTANY, 1'b0, 6'd3, pack_text("xyz"), "q", CLOSE_ON_CHAR, 1);
    add_row(1'b1, RULE_ALL, 1'b0, 6'd0, '0, "", CLOSE_ON_MARKER, 1);
    add_row(1'b1, RULE_NOTALL, 1'b0, 6'd2, pack_text("ab"), "ba", CLOSE_ON_CHAR, 0);
    add_row(1'b1, RULE_ENDS, 1'b1, 6'd0, '0, "\377", CLOSE_ON_CHAR, 1);
    // A reserved rule code never matches.
    add_row(1'b1, RULE_RESERVED, 1'b0, 6'd1, pack_text("a"), "a", CLOSE_ON_CHAR, 0);
    // Oversized length: the only hit sits in the last pattern slot, which only
    // counts when the length saturates to the full store.
    add_row(1'b1, RULE_ANY, 1'b0, 6'd63, {8'h71, 248'h0}, "q", CLOSE_ON_CHAR, -1);
    // An ignored empty request inside the object adds no character.
    add_row(1'b1, RULE_EQ, 1'b0, 6'd2, pack_text("ab"), "ab", CLOSE_WITH_NOISE, 1);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].write_setup) begin
        drain_results();
        load_setup(directed_rows[i].setup);
      end
      text_object(directed_rows[i].text, directed_rows[i].close_mode);
      send_object(directed_rows[i].known_match);
    end

    // Random phases: new settings, then a handful of objects under them. One
    // stretch in the middle runs with no gaps and no stalls at all.
    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      drain_results();
      load_setup(random_setup());
      repeat ($urandom_range(1, 6)) begin
        calm = (items_sent - base >= 300) && (items_sent - base < 500);
        compose_object();
        send_object(-1);
      end
    end
    calm = 1'b0;

    drain_results();
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: a correct run needs a small fraction of this.
  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

### sim.f
rtl/core/srm_pkg.sv
rtl/core/srm_front.sv
rtl/core/srm_queue.sv
rtl/core/srm_back.sv
rtl/core/string_rule_matcher.sv
tb/tb_string_rule_matcher.sv
